// File: src/edf_pkg.sv
// edf_pkg: shared types, constants and helpers for the edf periodic task scheduler
// no dependencies; imported by edf_periodic_task_scheduler and its testbench
`timescale 1ns / 1ps

package edf_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int DIV_CNT_W = $clog2(TIME_BITS);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        time_t       release_time;
        time_t       abs_deadline;
        logic [15:0] remaining_exec;
        logic [15:0] jobs_left;
        logic [15:0] stored_period;
        logic [15:0] stored_exec;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_WRITE,
        ST_DONE
    } state_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

// File: src/edf_periodic_task_scheduler.sv
// edf_periodic_task_scheduler: preemptive earliest-deadline-first scheduler for periodic tasks
// depends on edf_pkg; task table held in one synchronous ram inside this module
`timescale 1ns / 1ps

// One item at a time. The whole task table lives in a single-port-read ram
// with a registered read; every item sweeps the active entries through
// that read port, one entry per cycle; the active task count is at most 16.
// After a result is handed to the output register the block returns to idle
// before the next transfer is taken. A tick that finishes a job whose next
// release has fallen behind the current time also passes through the
// bit-serial remainder unit that snaps the release onto the period grid. No
// clearing pass: entries must be loaded before they are made active. A
// finished result sits in the output register while the next item is taken
// in; a second result waits until the first one has been transferred.

module edf_periodic_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,       // active_tasks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,        // task_index[3:0], task_period[19:4],
                                        // task_exec_time[35:20], task_jobs[51:36], zero fill
    input  logic        s_tuser,        // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata         // running_task[3:0], cpu_idle[4], preempted[5],
                                        // job_completed[6], deadline_missed[7],
                                        // response_time[39:8], all_done[40],
                                        // current_time[72:41], zero fill
);
    import edf_pkg::*;

    entry_t mem [MAX_TASKS];
    entry_t rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    state_t state_reg, state_next;

    logic [4:0]       active_reg;
    logic [CNT_W-1:0] n_tasks;
    logic             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      per_in_reg, ex_in_reg, jobs_in_reg;

    time_t            now_reg;
    logic             run_valid_reg;
    logic [IDX_W-1:0] run_idx_reg;

    logic [CNT_W-1:0] scan_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    time_t            best_dl_reg;
    logic             run_ok_reg;
    time_t            run_dl_reg;
    logic [CNT_W-1:0] nz_reg;
    logic [IDX_W-1:0] cur_reg;

    entry_t           ent_reg;
    time_t            rel_reg;
    time_t            dvd_reg;
    logic [15:0]      rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic             out_valid_reg;
    logic [79:0]      m_data_reg;
    logic [IDX_W-1:0] o_run_reg;
    logic             o_idle_reg, o_pre_reg, o_done_reg, o_miss_reg, o_all_reg;
    time_t            o_resp_reg;

    logic scan_end;
    logic elig;
    logic rv_eff;
    logic take_best;
    logic [16:0] div_t;
    logic [15:0] div_r;
    time_t now_inc;
    time_t r0;

    assign n_tasks  = (active_reg > 5'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(active_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign scan_end = (scan_reg >= n_tasks) && !pend_reg;
    assign elig     = (rd_data.jobs_left != 16'd0) && (rd_data.release_time <= now_reg);
    assign rv_eff   = run_valid_reg && run_ok_reg;
    assign take_best = found_reg && (!rv_eff || (best_dl_reg < run_dl_reg));
    assign now_inc  = sat_add(now_reg, time_t'(1));
    assign r0       = sat_add(rd_data.release_time, time_t'(rd_data.stored_period));
    assign div_t    = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign div_r    = (div_t >= {1'b0, ent_reg.stored_period}) ?
                      16'(div_t - {1'b0, ent_reg.stored_period}) : div_t[15:0];
    assign rd_addr  = (state_reg == ST_SCAN) ? scan_reg[IDX_W-1:0] : cur_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = rd_data;
        case (state_reg)
            ST_LOAD:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata.release_time   = '0;
                mem_wdata.abs_deadline   = time_t'(per_in_reg);
                mem_wdata.remaining_exec = ex_in_reg;
                mem_wdata.jobs_left      = jobs_in_reg;
                mem_wdata.stored_period  = per_in_reg;
                mem_wdata.stored_exec    = ex_in_reg;
            end
            ST_CALC:
            begin
                if (rd_data.remaining_exec > 16'd1)
                begin
                    mem_we = 1'b1;
                    mem_wdata.remaining_exec = rd_data.remaining_exec - 16'd1;
                end
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = ent_reg;
                mem_wdata.release_time   = rel_reg;
                mem_wdata.abs_deadline   = sat_add(rel_reg, time_t'(ent_reg.stored_period));
                mem_wdata.remaining_exec = ent_reg.stored_exec;
                mem_wdata.jobs_left      = ent_reg.jobs_left - 16'd1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tuser == CMD_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (cmd_reg == CMD_LOAD || (!found_reg && !rv_eff))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (rd_data.remaining_exec > 16'd1)
                begin
                    state_next = ST_DONE;
                end
                else if (r0 < now_reg && rd_data.stored_period != 16'd0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(TIME_BITS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 5'd1;
            cmd_reg       <= CMD_LOAD;
            idx_reg       <= '0;
            per_in_reg    <= '0;
            ex_in_reg     <= '0;
            jobs_in_reg   <= '0;
            now_reg       <= '0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_dl_reg   <= '0;
            run_ok_reg    <= 1'b0;
            run_dl_reg    <= '0;
            nz_reg        <= '0;
            cur_reg       <= '0;
            ent_reg       <= '0;
            rel_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            m_data_reg    <= '0;
            o_run_reg     <= '0;
            o_idle_reg    <= 1'b0;
            o_pre_reg     <= 1'b0;
            o_done_reg    <= 1'b0;
            o_miss_reg    <= 1'b0;
            o_all_reg     <= 1'b0;
            o_resp_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg     <= s_tuser;
                        idx_reg     <= s_tdata[3:0];
                        per_in_reg  <= s_tdata[19:4];
                        ex_in_reg   <= s_tdata[35:20];
                        jobs_in_reg <= s_tdata[51:36];
                        scan_reg    <= '0;
                        pend_reg    <= 1'b0;
                        found_reg   <= 1'b0;
                        run_ok_reg  <= 1'b0;
                        nz_reg      <= '0;
                        o_run_reg   <= '0;
                        o_idle_reg  <= 1'b0;
                        o_pre_reg   <= 1'b0;
                        o_done_reg  <= 1'b0;
                        o_miss_reg  <= 1'b0;
                        o_resp_reg  <= '0;
                    end
                end
                ST_LOAD:
                begin
                    // reloading the running entry drops it silently
                    if (run_valid_reg && run_idx_reg == idx_reg)
                    begin
                        run_valid_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= (scan_reg < n_tasks);
                    pidx_reg <= scan_reg[IDX_W-1:0];
                    if (scan_reg < n_tasks)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    if (pend_reg)
                    begin
                        if (rd_data.jobs_left != 16'd0)
                        begin
                            nz_reg <= nz_reg + CNT_W'(1);
                        end
                        if (elig && (!found_reg || rd_data.abs_deadline < best_dl_reg))
                        begin
                            found_reg    <= 1'b1;
                            best_idx_reg <= pidx_reg;
                            best_dl_reg  <= rd_data.abs_deadline;
                        end
                        if (elig && pidx_reg == run_idx_reg)
                        begin
                            run_ok_reg <= 1'b1;
                            run_dl_reg <= rd_data.abs_deadline;
                        end
                    end
                    if (scan_end)
                    begin
                        o_all_reg <= (nz_reg == '0);
                        if (cmd_reg == CMD_TICK)
                        begin
                            if (!found_reg && !rv_eff)
                            begin
                                o_idle_reg    <= 1'b1;
                                run_valid_reg <= 1'b0;
                                now_reg       <= now_inc;
                            end
                            else
                            begin
                                cur_reg   <= take_best ? best_idx_reg : run_idx_reg;
                                o_pre_reg <= rv_eff && take_best;
                            end
                        end
                    end
                end
                ST_READ:
                begin
                    now_reg <= now_inc;
                end
                ST_CALC:
                begin
                    ent_reg       <= rd_data;
                    o_run_reg     <= cur_reg;
                    run_idx_reg   <= cur_reg;
                    run_valid_reg <= 1'b1;
                    if (rd_data.remaining_exec <= 16'd1)
                    begin
                        run_valid_reg <= 1'b0;
                        o_done_reg    <= 1'b1;
                        o_miss_reg    <= (rd_data.abs_deadline < now_reg);
                        o_resp_reg    <= now_reg - rd_data.release_time;
                        o_all_reg     <= ((nz_reg - CNT_W'(rd_data.jobs_left == 16'd1)) == '0);
                        rel_reg       <= (r0 < now_reg) ? now_reg : r0;
                        dvd_reg       <= now_reg - r0;
                        rem_reg       <= '0;
                        div_cnt_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    // restoring remainder, one dividend bit per cycle
                    rem_reg     <= div_r;
                    dvd_reg     <= {dvd_reg[TIME_BITS-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(TIME_BITS - 1))
                    begin
                        rel_reg <= (div_r == 16'd0) ? now_reg :
                                   sat_add(now_reg, time_t'(ent_reg.stored_period - div_r));
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        m_data_reg    <= {7'd0, now_reg[31:0], o_all_reg, o_resp_reg[31:0],
                                          o_miss_reg, o_done_reg, o_pre_reg, o_idle_reg,
                                          o_run_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: tb/edf_periodic_task_scheduler_tb.sv
// testbench for edf_periodic_task_scheduler: directed and random load/tick streams
// checked against an in-bench edf predictor; depends on edf_pkg and the scheduler rtl
`timescale 1ns / 1ps

module edf_periodic_task_scheduler_tb;

    import edf_pkg::*;

    typedef struct {
        logic [3:0]  running_task;
        logic        cpu_idle;
        logic        preempted;
        logic        job_completed;
        logic        deadline_missed;
        logic [31:0] response_time;
        logic        all_done;
        logic [31:0] current_time;
    } sched_out_t;

    class edf_scoreboard;
        logic [31:0] release_t [16];
        logic [31:0] deadline_t [16];
        logic [15:0] exec_left [16];
        logic [15:0] jobs_left [16];
        logic [15:0] period_cfg [16];
        logic [15:0] exec_cfg [16];
        logic        run_valid;
        logic [3:0]  run_idx;
        logic [31:0] now_t;
        logic [4:0]  active_n;
        sched_out_t  expected_q [$];
        int          mismatches;

        function new();
            run_valid  = 0;
            run_idx    = 0;
            now_t      = 0;
            active_n   = 1;
            mismatches = 0;
        endfunction

        function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function int task_count();
            return (active_n > 16) ? 16 : int'(active_n);
        endfunction

        function bit ready_to_run(int i);
            return i < task_count() && jobs_left[i] != 0 && release_t[i] <= now_t;
        endfunction

        // predict the result of one accepted item and queue it
        function void note_input(logic cmd, logic [55:0] data);
            sched_out_t  o;
            int          idx;
            int          best;
            int          cur;
            bit          found;
            logic [31:0] per;
            logic [31:0] r;
            logic [31:0] rem;
            o = '{default: '0};
            idx = int'(data[3:0]);
            if (cmd == CMD_LOAD) begin
                period_cfg[idx] = data[19:4];
                exec_cfg[idx]   = data[35:20];
                exec_left[idx]  = data[35:20];
                jobs_left[idx]  = data[51:36];
                release_t[idx]  = 0;
                deadline_t[idx] = {16'd0, data[19:4]};
                if (run_valid && run_idx == idx) run_valid = 0;
            end else begin
                found = 0;
                best  = 0;
                for (int i = 0; i < task_count(); i++)
                    if (ready_to_run(i) && (!found || deadline_t[i] < deadline_t[best])) begin
                        best  = i;
                        found = 1;
                    end
                if (run_valid && !ready_to_run(int'(run_idx))) run_valid = 0;
                cur = best;
                if (run_valid) begin
                    cur = int'(run_idx);
                    if (found && deadline_t[best] < deadline_t[cur]) begin
                        cur = best;
                        o.preempted = 1;
                    end
                end
                now_t = sat_sum(now_t, 1);
                if (!found && !run_valid) begin
                    o.cpu_idle = 1;
                    o.preempted = 0;
                end else begin
                    o.running_task = cur[3:0];
                    run_valid = 1;
                    run_idx   = cur[3:0];
                    if (exec_left[cur] <= 1) begin
                        per = {16'd0, period_cfg[cur]};
                        o.job_completed   = 1;
                        o.deadline_missed = deadline_t[cur] < now_t;
                        o.response_time   = now_t - release_t[cur];
                        r = sat_sum(release_t[cur], per);
                        if (r < now_t) begin
                            if (per == 0) r = now_t;
                            else begin
                                rem = (now_t - r) % per;
                                r = (rem == 0) ? now_t : sat_sum(now_t, per - rem);
                            end
                        end
                        release_t[cur]  = r;
                        deadline_t[cur] = sat_sum(r, per);
                        exec_left[cur]  = exec_cfg[cur];
                        jobs_left[cur]  = jobs_left[cur] - 16'd1;
                        run_valid = 0;
                    end else begin
                        exec_left[cur] = exec_left[cur] - 16'd1;
                    end
                end
            end
            o.all_done = 1;
            for (int i = 0; i < task_count(); i++)
                if (jobs_left[i] != 0) o.all_done = 0;
            o.current_time = now_t;
            expected_q.insert(expected_q.size(), o);
        endfunction

        function void check_result(logic [79:0] d);
            sched_out_t e;
            sched_out_t a;
            a.running_task    = d[3:0];
            a.cpu_idle        = d[4];
            a.preempted       = d[5];
            a.job_completed   = d[6];
            a.deadline_missed = d[7];
            a.response_time   = d[39:8];
            a.all_done        = d[40];
            a.current_time    = d[72:41];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", d);
                return;
            end
            e = expected_q.pop_front();
            if (a.running_task !== e.running_task || a.cpu_idle !== e.cpu_idle ||
                a.preempted !== e.preempted || a.job_completed !== e.job_completed ||
                a.deadline_missed !== e.deadline_missed ||
                a.response_time !== e.response_time || a.all_done !== e.all_done ||
                a.current_time !== e.current_time) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp run=%0d idle=%b pre=%b done=%b miss=%b %s",
                             e.running_task, e.cpu_idle, e.preempted, e.job_completed,
                             e.deadline_missed, "");
                    $display("         exp resp=%0d all=%b t=%0d",
                             e.response_time, e.all_done, e.current_time);
                    $display("         act run=%0d idle=%b pre=%b done=%b miss=%b %s",
                             a.running_task, a.cpu_idle, a.preempted, a.job_completed,
                             a.deadline_missed, "");
                    $display("         act resp=%0d all=%b t=%0d",
                             a.response_time, a.all_done, a.current_time);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    edf_scoreboard sched_sb;
    int unsigned   cycle_cnt = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    bit            pressure_done = 0;

    edf_periodic_task_scheduler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 1500000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one transfer on the input side, with random idle cycles before it outside a calm stretch
    task automatic send_item(logic cmd, int idx, int per, int ex, int jobs);
        bit calm;
        calm = items_sent >= 300 && items_sent < 520;
        while (!calm && $urandom_range(0, 99) < 24) @(negedge clk);
        s_tvalid = 1;
        s_tuser  = cmd;
        s_tdata  = {4'd0, jobs[15:0], ex[15:0], per[15:0], idx[3:0]};
        #1;
        while (!s_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        sched_sb.note_input(cmd, s_tdata);
        items_sent++;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic load_task(int idx, int per, int ex, int jobs);
        send_item(CMD_LOAD, idx, per, ex, jobs);
    endtask

    task automatic tick(int count);
        for (int k = 0; k < count; k++)
            send_item(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic set_active(int v);
        while (sched_sb.expected_q.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we   = 1;
        cfg_data = v[4:0];
        @(negedge clk);
        cfg_we = 0;
        sched_sb.active_n = v[4:0];
    endtask

    function automatic int rand_field(int lo, int hi);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(lo, hi);
    endfunction

    // receiver: random ready, a stretch of constant ready, one long hold-off while the sender keeps offering
    initial
    begin
        m_tready = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && results_seen == 150)
            begin
                pressure_done = 1;
                m_tready = 0;
                repeat (400) @(negedge clk);
            end
            if (results_seen >= 600 && results_seen < 800) m_tready = 1;
            else m_tready = ($urandom_range(0, 99) >= 24);
            #1;
            if (m_tvalid && m_tready)
            begin
                @(posedge clk);
                sched_sb.check_result(m_tdata);
                results_seen++;
            end
        end
    end

    initial
    begin
        int n;
        int limit;
        sched_sb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 5'd1;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = CMD_LOAD;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: entry 0 first so no sweep touches an unloaded entry
        load_task(0, 3, 1, 2);
        tick(4);
        load_task(0, 2, 3, 2);
        tick(3);
        load_task(1, 0, 0, 3);
        load_task(15, 65535, 65535, 65535);
        for (int i = 2; i < 15; i++) load_task(i, 1 + i, i % 3, i);
        set_active(16);
        tick(3);
        // reload of the running entry drops it without a preempt flag
        load_task(2, 5, 2, 1);
        tick(2);
        set_active(0);
        tick(1);
        set_active(31);
        tick(2);
        set_active(1);
        load_task(0, 1, 65535, 0);
        tick(1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: n = 16;
                1: n = 1;
                2: n = 2;
                3: n = 31;
                4: n = 0;
                default: n = $urandom_range(1, 31);
            endcase
            for (int i = 0; i < 16; i++)
                load_task(i, rand_field(1, 40), rand_field(0, 8), rand_field(0, 20));
            set_active(n);
            limit = 120;
            for (int k = 0; k < limit; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                    load_task($urandom_range(0, 15), rand_field(0, 40),
                              rand_field(0, 8), rand_field(0, 20));
                else
                    tick(1);
            end
        end

        while (sched_sb.expected_q.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (sched_sb.mismatches == 0 && sched_sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
src/edf_pkg.sv
src/edf_periodic_task_scheduler.sv
tb/edf_periodic_task_scheduler_tb.sv
